>>> src/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants for the serial-bus frame decoder with
// automatic line-polarity search.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CHAN_W        = 11;
    localparam int unsigned CHAN_IDX_W    = 4;
    localparam int unsigned NUM_CHANNELS  = 16;
    localparam int unsigned TIMEOUT_W     = 16;
    localparam int unsigned POS_W         = 5;
    // frame byte index of the end marker (frame is 25 bytes, 0..24)
    localparam int unsigned END_POS       = 24;
    // stored bytes 1..23 (data plus flags)
    localparam int unsigned STORE_DEPTH   = 23;
    // bytes 1..22 hold the packed channel data
    localparam int unsigned PAYLOAD_BYTES = 22;
    localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam logic [BYTE_W-1:0]    START_BYTE    = 8'h0F;
    localparam logic [BYTE_W-1:0]    END_BYTE      = 8'h00;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd350;
    localparam logic [TIMEOUT_W-1:0] COUNT_MAX     = 16'hFFFF;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_CHANNEL  = 1'b0,
        KIND_POLARITY = 1'b1
    } kind_t;

    // one request from the front end to the output sequencer
    typedef struct packed {
        kind_t                kind;
        logic                 invert;
        logic [PAYLOAD_W-1:0] frame;
    } job_t;

endpackage

>>> src/sbfd_front.sv
// ----------------------------------------------------------------------------
// sbfd_front
// Accepts bytes and ticks, tracks frame position, silence time and line
// polarity, and posts decode or polarity requests to the job queue.
// ----------------------------------------------------------------------------
module sbfd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbfd_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbfd_pkg::TIMEOUT_W-1:0] cfg_data,
    input  logic                           q_full,
    output logic                           push_valid,
    output sbfd_pkg::job_t                 push_job
);

    logic [sbfd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [sbfd_pkg::TIMEOUT_W-1:0] count_reg, count_next;
    logic [sbfd_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           invert_reg, invert_next;
    logic [sbfd_pkg::BYTE_W-1:0]    store_reg [sbfd_pkg::STORE_DEPTH];
    logic [sbfd_pkg::TIMEOUT_W-1:0] count_inc;
    logic                           accept;
    logic                           shift_en;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign count_inc = (count_reg == sbfd_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 1'b1;

    always_comb begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        invert_next   = invert_reg;
        shift_en      = 1'b0;
        push_valid    = 1'b0;
        push_job.kind = sbfd_pkg::KIND_CHANNEL;
        if (accept) begin
            if (sbfd_pkg::cmd_t'(s_tuser) == sbfd_pkg::CMD_TICK) begin
                count_next = count_inc;
                if (count_inc > timeout_reg) begin
                    // flip polarity, drop any partial frame
                    invert_next   = !invert_reg;
                    count_next    = '0;
                    pos_next      = '0;
                    push_valid    = 1'b1;
                    push_job.kind = sbfd_pkg::KIND_POLARITY;
                end
            end else if (pos_reg == '0) begin
                if (s_tdata == sbfd_pkg::START_BYTE) begin
                    pos_next = sbfd_pkg::POS_W'(1);
                end
            end else if (pos_reg != sbfd_pkg::POS_W'(sbfd_pkg::END_POS)) begin
                shift_en = 1'b1;
                pos_next = pos_reg + 1'b1;
            end else begin
                pos_next = '0;
                if (s_tdata == sbfd_pkg::END_BYTE) begin
                    count_next = '0;
                    push_valid = 1'b1;
                end
            end
        end
        push_job.invert = invert_next;
        for (int i = 0; i < sbfd_pkg::PAYLOAD_BYTES; i++) begin
            push_job.frame[i*sbfd_pkg::BYTE_W +: sbfd_pkg::BYTE_W] = store_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            count_reg   <= '0;
            invert_reg  <= 1'b1;
            timeout_reg <= sbfd_pkg::TIMEOUT_RESET;
        end else begin
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            invert_reg <= invert_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // frame bytes enter at the top; after 23 bytes entry 0 holds frame byte 1
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < sbfd_pkg::STORE_DEPTH - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[sbfd_pkg::STORE_DEPTH-1] <= s_tdata;
        end
    end

endmodule

>>> src/sbfd_queue.sv
// ----------------------------------------------------------------------------
// sbfd_queue
// Short FIFO of decode and polarity requests between front end and
// output sequencer.
// ----------------------------------------------------------------------------
module sbfd_queue #(
    parameter int unsigned DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  sbfd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output sbfd_pkg::job_t pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sbfd_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_valid && full))
        else $error("request pushed into full queue");

endmodule

>>> src/sbfd_back.sv
// ----------------------------------------------------------------------------
// sbfd_back
// Takes requests from the queue and emits results: sixteen unpacked
// channels for a frame, or one polarity report.
// ----------------------------------------------------------------------------
module sbfd_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  sbfd_pkg::job_t             q_job,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int unsigned CW = sbfd_pkg::CHAN_W;
    localparam int unsigned IW = sbfd_pkg::CHAN_IDX_W;
    localparam logic [IW-1:0] LAST_CH = IW'(sbfd_pkg::NUM_CHANNELS - 1);

    logic                           busy_reg, busy_next;
    logic [sbfd_pkg::PAYLOAD_W-1:0] work_reg, work_next;
    logic [IW-1:0]                  ch_reg, ch_next;
    sbfd_pkg::kind_t                kind_reg, kind_next;
    logic                           inv_reg, inv_next;

    logic                           m_valid_reg, m_valid_next;
    sbfd_pkg::kind_t                m_kind_reg, m_kind_next;
    logic [IW-1:0]                  m_index_reg, m_index_next;
    logic [CW-1:0]                  m_value_reg, m_value_next;
    logic                           m_last_reg, m_last_next;
    logic                           m_inv_reg, m_inv_next;
    logic                           out_free;
    logic                           is_pol;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = !busy_reg && q_valid;
    assign is_pol   = (kind_reg == sbfd_pkg::KIND_POLARITY);

    always_comb begin
        busy_next    = busy_reg;
        work_next    = work_reg;
        ch_next      = ch_reg;
        kind_next    = kind_reg;
        inv_next     = inv_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_index_next = m_index_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_inv_next   = m_inv_reg;
        if (busy_reg && out_free) begin
            m_valid_next = 1'b1;
            m_kind_next  = kind_reg;
            m_index_next = is_pol ? '0 : ch_reg;
            m_value_next = is_pol ? '0 : work_reg[CW-1:0];
            m_last_next  = is_pol || (ch_reg == LAST_CH);
            m_inv_next   = inv_reg;
            // advance to next channel
            work_next    = work_reg >> CW;
            ch_next      = ch_reg + 1'b1;
            if (is_pol || (ch_reg == LAST_CH)) begin
                busy_next = 1'b0;
            end
        end else if (out_free) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            busy_next = 1'b1;
            work_next = q_job.frame;
            ch_next   = '0;
            kind_next = q_job.kind;
            inv_next  = q_job.invert;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        ch_reg      <= ch_next;
        kind_reg    <= kind_next;
        inv_reg     <= inv_next;
        m_kind_reg  <= m_kind_next;
        m_index_reg <= m_index_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        m_inv_reg   <= m_inv_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_inv_reg, m_value_reg, m_index_reg};

    a_pol_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == sbfd_pkg::KIND_POLARITY) |->
        (m_last_reg && m_index_reg == '0 && m_value_reg == '0))
        else $error("polarity report with bad fields");

    a_last_on_final_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == sbfd_pkg::KIND_CHANNEL) |->
        (m_last_reg == (m_index_reg == LAST_CH)))
        else $error("tlast not aligned to final channel");

    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && m_kind_reg == sbfd_pkg::KIND_CHANNEL
         && !m_last_reg) |=>
        (m_valid_reg && m_kind_reg == sbfd_pkg::KIND_CHANNEL
         && m_index_reg == $past(m_index_reg) + 1'b1))
        else $error("channel run broken");

endmodule

>>> src/sbus_frame_decoder_autopolarity_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_autopolarity_unit
// Serial-bus frame decoder with automatic line-polarity search.
// ----------------------------------------------------------------------------
// Input stream (s_*): one request per received byte (tuser = 0, byte in
// tdata[7:0]) or per millisecond tick (tuser = 1). A 25-byte frame opened by
// 0x0F and closed by 0x00 yields a run of sixteen 11-bit channel results;
// a bad end byte drops the frame. Ticks with no good frame for longer than
// the silence timeout flip the polarity flag and yield one report (tuser = 1).
// Output stream (m_*): tdata = {invert, channel_value, channel_index},
// tuser = kind, tlast marks the end of a run.
// Config channel (cfg_*): writes the 16-bit silence timeout, always ready.
// A result run leaves via the request queue, the sequencer's work registers
// and the output register; the run then streams one channel per cycle while
// m_tready is high. The output sequencer takes no new request until it has
// emitted a frame's last channel or the polarity report.
// A 2-entry request queue lets the front keep accepting while the output is
// stalled; s_tready drops only when that queue is full.
// Reset: polarity flag set (inverted), hunting for start, counter cleared,
// timeout back to 350.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_autopolarity_unit #(
    parameter int unsigned QUEUE_DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [3:0] channel_index,
                                                      // [14:4] channel_value,
                                                      // [15] invert
    output logic                           m_tuser,   // [0] kind
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbfd_pkg::TIMEOUT_W-1:0] cfg_data
);

    logic           q_full;
    logic           push_valid;
    sbfd_pkg::job_t push_job;
    logic           q_pop;
    logic           q_valid;
    sbfd_pkg::job_t q_job;

    sbfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    sbfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_job    (q_job)
    );

    sbfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
